/* hdl/lkr_pkg.sv */
package lkr_pkg;

  // Table geometry
  localparam int NUM_LAYERS = 8;
  localparam int NUM_ROWS   = 8;
  localparam int NUM_COLS   = 16;
  localparam int TABLE_SIZE = NUM_LAYERS * NUM_ROWS * NUM_COLS;

  // Layer mask size fixed by the command format
  localparam int MASK_LAYERS = 32;

  localparam int TBL_AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int LAY_W  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int CNT_W  = $clog2(NUM_LAYERS + 1);

  // Command codes
  localparam logic [1:0] CMD_ACTIVATE   = 2'd0;
  localparam logic [1:0] CMD_DEACTIVATE = 2'd1;
  localparam logic [1:0] CMD_WRITE      = 2'd2;
  localparam logic [1:0] CMD_RESOLVE    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_DEFAULT_LAYER    = 2'd0;
  localparam logic [1:0] REG_TRANSPARENT_CODE = 2'd1;
  localparam logic [1:0] REG_NO_KEY_CODE      = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POST
  } lkr_state_t;

  typedef enum logic [1:0] {
    RES_CMD,
    RES_HIT,
    RES_NOKEY
  } lkr_res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic         start;
    logic         step;
    logic         load;
    lkr_res_sel_t res_sel;
  } lkr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
  } lkr_stat_t;

endpackage

/* hdl/lkr_dpath.sv */
module lkr_dpath import lkr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lkr_cmd_t    cmd,
  output lkr_stat_t   stat,
  input  logic [1:0]  command,
  input  logic [7:0]  layer,
  input  logic [2:0]  row,
  input  logic [3:0]  column,
  input  logic [7:0]  entry_code,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        ok,
  output logic [7:0]  key_code
);

  logic [2:0]        default_layer;
  logic [7:0]        transparent_code;
  logic [7:0]        no_key_code;
  logic [31:0]       active_layers;
  logic [7:0]        key_table [TABLE_SIZE];
  logic [7:0]        rdata;
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic              pend_on;
  logic              item_ok;
  logic [2:0]        row_q;
  logic [3:0]        col_q;

  logic              pos_ok;
  logic              mask_ok;
  logic              wr_ok;
  logic              wr_en;
  logic [TBL_AW-1:0] wr_addr;
  logic [LAY_W-1:0]  cur_lay;
  logic              cur_on;
  logic              can_issue;
  logic              rd_en;
  logic [TBL_AW-1:0] rd_addr;
  logic [31:0]       lay_bit;

  // Decode the incoming beat
  always_comb begin
    pos_ok  = (32'(row) < 32'(NUM_ROWS)) && (32'(column) < 32'(NUM_COLS));
    mask_ok = 32'(layer) < 32'(MASK_LAYERS);
    wr_ok   = (32'(layer) < 32'(NUM_LAYERS)) && pos_ok;
    wr_en   = cmd.start && (command == CMD_WRITE) && wr_ok;
    wr_addr = TBL_AW'((32'(layer) * NUM_ROWS + 32'(row)) * NUM_COLS + 32'(column));
    lay_bit = 32'(1) << layer[4:0];
  end

  // Scan pointer: cnt holds the next layer plus one
  always_comb begin
    cur_lay   = LAY_W'(cnt - 1'b1);
    cur_on    = ((active_layers >> cur_lay) & 32'(1)) != 32'(0) ||
                (32'(cur_lay) == 32'(default_layer));
    can_issue = 32'(cnt) > 32'(default_layer);
    rd_en     = cmd.step && can_issue;
    rd_addr   = TBL_AW'((32'(cur_lay) * NUM_ROWS + 32'(row_q)) * NUM_COLS + 32'(col_q));
    stat.hit      = pend && pend_on && (rdata != transparent_code);
    stat.scan_end = !pend && !can_issue;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_layer    <= 3'd0;
      transparent_code <= 8'd1;
      no_key_code      <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEFAULT_LAYER:    default_layer    <= cfg_data[2:0];
        REG_TRANSPARENT_CODE: transparent_code <= cfg_data;
        REG_NO_KEY_CODE:      no_key_code      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active layer mask
  always_ff @(posedge clk) begin
    if (rst) begin
      active_layers <= '0;
    end else if (cmd.start && mask_ok) begin
      if (command == CMD_ACTIVATE) begin
        active_layers <= active_layers | lay_bit;
      end else if (command == CMD_DEACTIVATE) begin
        active_layers <= active_layers & ~lay_bit;
      end
    end
  end

  // Key table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_table[wr_addr] <= entry_code;
    end
  end

  // Key table read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= key_table[rd_addr];
    end
  end

  // Scan control: restart on accept, walk down one layer a cycle while the controller steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.start) begin
      cnt  <= pos_ok ? CNT_W'(NUM_LAYERS) : '0;
      pend <= 1'b0;
    end else if (cmd.step) begin
      pend <= can_issue;
      if (can_issue) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Hold the beat fields the scan needs
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_q <= row;
      col_q <= column;
      unique case (command)
        CMD_ACTIVATE, CMD_DEACTIVATE: item_ok <= mask_ok;
        CMD_WRITE:                    item_ok <= wr_ok;
        CMD_RESOLVE:                  item_ok <= pos_ok;
        default:                      item_ok <= 1'b0;
      endcase
    end
    if (rd_en) begin
      pend_on <= cur_on;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (cmd.res_sel)
        RES_HIT: begin
          ok       <= 1'b1;
          key_code <= rdata;
        end
        RES_NOKEY: begin
          ok       <= item_ok;
          key_code <= no_key_code;
        end
        default: begin
          ok       <= item_ok;
          key_code <= 8'd0;
        end
      endcase
    end
  end

endmodule

/* hdl/lkr_ctrl.sv */
module lkr_ctrl import lkr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  output logic       out_valid,
  input  logic       out_stall,
  output lkr_cmd_t   cmd,
  input  lkr_stat_t  stat
);

  lkr_state_t state;
  lkr_state_t state_next;
  logic       slot_free;
  logic       accept;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on load, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.start   = 1'b0;
    cmd.step    = 1'b0;
    cmd.load    = 1'b0;
    cmd.res_sel = RES_CMD;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.start  = 1'b1;
          state_next = (command == CMD_RESOLVE) ? S_SCAN : S_POST;
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.scan_end) begin
          cmd.res_sel = stat.hit ? RES_HIT : RES_NOKEY;
          if (slot_free) begin
            cmd.load   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_POST: begin
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Never overwrite a result that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> slot_free)
    else $error("result loaded over a waiting beat");

  // An accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block not busy after accept");

  // A found key with a free slot ends the scan with a result
  a_hit_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.hit && slot_free) |=> (state == S_IDLE && out_valid))
    else $error("hit did not produce a result");

  // The scan never steps once it has a result to hand over
  a_no_step_on_end: assert property (@(posedge clk) disable iff (rst)
    (stat.hit || stat.scan_end) |-> !cmd.step)
    else $error("scan stepped past its end");

endmodule

/* hdl/layered_keymap_resolver.sv */
// Channel  Handshake              Payload
// in       in_valid / in_stall    command, layer, row, column, entry_code
// out      out_valid / out_stall  ok, key_code
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (0 default, 1 transparent, 2 no key)
//
// Activate, deactivate and write pass through the post state and load the result register
// once it is free. Resolve reads layers from the top down to default_layer, one table
// read per cycle through the single key table read port, and ends at the first hit.
// rst is synchronous: clears the layer mask, config registers and scan state, the key table is not cleared.
// One item at a time; the result register lets a new item in while a beat waits.
// cfg_ready is always high.
module layered_keymap_resolver import lkr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] layer,
  input  logic [2:0] row,
  input  logic [3:0] column,
  input  logic [7:0] entry_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       ok,
  output logic [7:0] key_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  lkr_cmd_t  cmd;
  lkr_stat_t stat;

  assign cfg_ready = 1'b1;

  lkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  lkr_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .layer      (layer),
    .row        (row),
    .column     (column),
    .entry_code (entry_code),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ok         (ok),
    .key_code   (key_code)
  );

endmodule
